/* design/lddw_pkg.sv */
// Shared types and constants for the two-wire LED driver writer.
`default_nettype none

package lddw_pkg;

  localparam int BUFFER_DEPTH = 16;
  localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_ON = 1'b1;

  localparam logic [7:0] CMD_DATA = 8'b0100_0000;
  localparam logic [7:0] CMD_ADDR = 8'b1100_0000;
  localparam logic [7:0] CMD_CTRL = 8'b1000_0000;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] slot;
    logic [7:0] seg_byte;
    logic [4:0] byte_count;
    logic [1:0] first_digit;
  } in_item_t;

  typedef struct packed {
    logic clk_line;
    logic dio_line;
    logic busy_res;
  } out_item_t;

endpackage

`default_nettype wire

/* design/lddw_core.sv */
// Segment buffer memory and pin phase sequencer of the two-wire LED driver writer.
`default_nettype none

module lddw_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire lddw_pkg::in_item_t req,
  input  wire logic [2:0]         brightness,
  input  wire logic               display_on,
  output lddw_pkg::out_item_t     tick_res
);
  import lddw_pkg::*;

  typedef enum logic [8:0] {
    PH_IDLE     = 9'b0_0000_0001,
    PH_START    = 9'b0_0000_0010,
    PH_CLK_LOW  = 9'b0_0000_0100,
    PH_DATA     = 9'b0_0000_1000,
    PH_CLK_HIGH = 9'b0_0001_0000,
    PH_BYTE_END = 9'b0_0010_0000,
    PH_STOP_DIO = 9'b0_0100_0000,
    PH_STOP_CLK = 9'b0_1000_0000,
    PH_STOP_REL = 9'b1_0000_0000
  } phase_t;

  logic [7:0]  seg_mem [BUFFER_DEPTH];
  logic [7:0]  rd_data;

  phase_t      phase, phase_next;
  logic [1:0]  frame_index, frame_index_next;
  logic [4:0]  byte_index, byte_index_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [4:0]  send_count, send_count_next;
  logic [1:0]  send_addr, send_addr_next;
  logic        clk_level, clk_level_next;
  logic        dio_level, dio_level_next;

  logic        busy;
  logic        do_load;
  logic [7:0]  ctrl_cmd;

  assign busy     = (phase != PH_IDLE);
  assign do_load  = accept && (req.func == FUNC_LOAD) && !busy
                    && (32'(req.slot) < BUFFER_DEPTH);
  assign ctrl_cmd = CMD_CTRL + {4'b0000, display_on, brightness};

  // The buffer is written only while idle, and the read address follows the
  // byte index, so the registered read data is settled long before a byte end.
  always_ff @(posedge clk) begin
    if (do_load) begin
      seg_mem[ADDR_W'(req.slot)] <= req.seg_byte;
    end
    rd_data <= seg_mem[ADDR_W'(byte_index)];
  end

  always_comb begin
    phase_next       = phase;
    frame_index_next = frame_index;
    byte_index_next  = byte_index;
    bit_index_next   = bit_index;
    shift_reg_next   = shift_reg;
    send_count_next  = send_count;
    send_addr_next   = send_addr;
    clk_level_next   = clk_level;
    dio_level_next   = dio_level;
    if (accept && (req.func == FUNC_START) && !busy) begin
      send_count_next  = (32'(req.byte_count) > BUFFER_DEPTH) ? 5'(BUFFER_DEPTH)
                                                              : req.byte_count;
      send_addr_next   = req.first_digit;
      frame_index_next = 2'd0;
      shift_reg_next   = CMD_DATA;
      byte_index_next  = 5'd0;
      bit_index_next   = 3'd0;
      phase_next       = PH_START;
    end else if (accept && (req.func == FUNC_TICK)) begin
      unique case (phase)
        PH_START: begin
          dio_level_next = 1'b0;
          phase_next     = PH_CLK_LOW;
        end
        PH_CLK_LOW: begin
          clk_level_next = 1'b0;
          phase_next     = PH_DATA;
        end
        PH_DATA: begin
          dio_level_next = shift_reg[0];
          phase_next     = PH_CLK_HIGH;
        end
        PH_CLK_HIGH: begin
          clk_level_next = 1'b1;
          shift_reg_next = {1'b0, shift_reg[7:1]};
          if (bit_index == 3'd7) begin
            bit_index_next = 3'd0;
            phase_next     = PH_BYTE_END;
          end else begin
            bit_index_next = bit_index + 3'd1;
            phase_next     = PH_CLK_LOW;
          end
        end
        PH_BYTE_END: begin
          clk_level_next = 1'b0;
          if ((frame_index == 2'd1) && (byte_index < send_count)
              && (32'(byte_index) < BUFFER_DEPTH)) begin
            shift_reg_next  = rd_data;
            byte_index_next = byte_index + 5'd1;
            phase_next      = PH_CLK_LOW;
          end else begin
            phase_next = PH_STOP_DIO;
          end
        end
        PH_STOP_DIO: begin
          dio_level_next = 1'b0;
          phase_next     = PH_STOP_CLK;
        end
        PH_STOP_CLK: begin
          clk_level_next = 1'b1;
          phase_next     = PH_STOP_REL;
        end
        PH_STOP_REL: begin
          dio_level_next = 1'b1;
          byte_index_next = 5'd0;
          if (frame_index >= 2'd2) begin
            frame_index_next = 2'd0;
            phase_next       = PH_IDLE;
          end else begin
            frame_index_next = frame_index + 2'd1;
            shift_reg_next   = (frame_index == 2'd0) ? (CMD_ADDR + {6'd0, send_addr})
                                                     : ctrl_cmd;
            bit_index_next   = 3'd0;
            phase_next       = PH_START;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      frame_index <= 2'd0;
      byte_index  <= 5'd0;
      bit_index   <= 3'd0;
      shift_reg   <= 8'd0;
      send_count  <= 5'd0;
      send_addr   <= 2'd0;
      clk_level   <= 1'b1;
      dio_level   <= 1'b1;
    end else begin
      phase       <= phase_next;
      frame_index <= frame_index_next;
      byte_index  <= byte_index_next;
      bit_index   <= bit_index_next;
      shift_reg   <= shift_reg_next;
      send_count  <= send_count_next;
      send_addr   <= send_addr_next;
      clk_level   <= clk_level_next;
      dio_level   <= dio_level_next;
    end
  end

  assign tick_res = '{clk_line: clk_level_next,
                      dio_line: dio_level_next,
                      busy_res: (phase_next != PH_IDLE)};

endmodule

`default_nettype wire

/* design/led_driver_two_wire_writer.sv */
// Top level of the two-wire LED driver writer: request handshake, result register, settings.
//
// The block takes one request per clock unless the result register is stalled: a load
// writes the segment buffer memory, a start primes the three frames, and a tick advances the
// pins by one phase and places its result in an output register. A new request is taken while
// that register is empty or being drained, so requests flow back to back at one per clock
// while results are drained. The buffer memory has a single write port.
// Loads and starts are ignored while a transfer is in progress, and only ticks give results.
`default_nettype none

module led_driver_two_wire_writer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_ready,
  input  wire lddw_pkg::in_item_t            item,
  output logic                               result_valid,
  input  wire logic                          result_ready,
  output lddw_pkg::out_item_t                result,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lddw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lddw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lddw_pkg::*;

  logic       accept;
  logic [2:0] brightness;
  logic       display_on;
  out_item_t  tick_res;

  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= 3'd7;
      display_on <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BRIGHTNESS: brightness <= cfg_data[2:0];
        CFG_DISPLAY_ON: display_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lddw_core u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .req        (item),
    .brightness (brightness),
    .display_on (display_on),
    .tick_res   (tick_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && (item.func == FUNC_TICK)) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (item.func == FUNC_TICK)) begin
      result <= tick_res;
    end
  end

endmodule

`default_nettype wire

/* design/lddw_checker.sv */
// Port-level checks of the two-wire LED driver writer and their binding to the top level.
`default_nettype none

module lddw_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            item_valid,
  input wire logic                            item_ready,
  input wire lddw_pkg::in_item_t              item,
  input wire logic                            result_valid,
  input wire logic                            result_ready,
  input wire lddw_pkg::out_item_t             result,
  input wire logic                            cfg_valid,
  input wire logic                            cfg_ready,
  input wire logic [lddw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input wire logic [lddw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lddw_pkg::*;

  // A stalled result holds its value.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // Every tick request produces a result in the next cycle.
  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (item.func == FUNC_TICK) |=> result_valid)
    else $error("tick request gave no result");

  // A new result appears only after a tick request.
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_valid && item_ready && (item.func == FUNC_TICK)))
    else $error("result without a tick request");

  // Once the transfer is over both lines are released.
  a_idle_lines: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.busy_res |-> result.clk_line && result.dio_line)
    else $error("lines not released when idle");

endmodule

bind led_driver_two_wire_writer lddw_checker u_lddw_checker (.*);

`default_nettype wire

/* tb/sv/tb_led_driver_two_wire_writer.sv */
// Self-checking testbench for the two-wire LED driver writer with a pin-level scoreboard.
`default_nettype none

module tb_led_driver_two_wire_writer;
  timeunit 1ns;
  timeprecision 1ps;

  import lddw_pkg::*;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int ITEM_TARGET = 1800;
  localparam int PHASES = 8;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START, PH_CLK_LOW, PH_DATA, PH_CLK_HIGH,
    PH_BYTE_END, PH_STOP_DIO, PH_STOP_CLK, PH_STOP_REL
  } pin_phase_t;

  class pin_scoreboard;
    logic [2:0] brightness;
    logic on_bit;
    logic [7:0] segs [BUFFER_DEPTH];
    logic [BUFFER_DEPTH-1:0] loaded;
    logic [1:0] frame;
    logic [4:0] byte_idx;
    logic [2:0] bit_idx;
    pin_phase_t phase;
    logic [7:0] shifter;
    logic [4:0] send_count;
    logic [1:0] digit;
    logic clk_lvl;
    logic dio_lvl;
    out_item_t expected_pins[$];
    int errors;
    int results_seen;

    function new();
      brightness = 3'd7;
      on_bit = 1'b1;
      loaded = '0;
      foreach (segs[i]) segs[i] = 8'h00;
      frame = '0;
      byte_idx = '0;
      bit_idx = '0;
      phase = PH_IDLE;
      shifter = '0;
      send_count = '0;
      digit = '0;
      clk_lvl = 1'b1;
      dio_lvl = 1'b1;
      errors = 0;
      results_seen = 0;
    endfunction

    function bit busy();
      return phase != PH_IDLE;
    endfunction

    function int loaded_prefix();
      int n;
      n = 0;
      while (n < BUFFER_DEPTH && loaded[n]) n++;
      return n;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_BRIGHTNESS) brightness = data[2:0];
      else if (idx == CFG_DISPLAY_ON) on_bit = data[0];
    endfunction

    function void open_frame();
      case (frame)
        2'd0: shifter = CMD_DATA;
        2'd1: shifter = CMD_ADDR + {6'd0, digit};
        default: shifter = CMD_CTRL + {4'd0, on_bit, brightness};
      endcase
      byte_idx = '0;
      bit_idx = '0;
      phase = PH_START;
    endfunction

    function void step_pins();
      case (phase)
        PH_START: begin
          dio_lvl = 1'b0;
          phase = PH_CLK_LOW;
        end
        PH_CLK_LOW: begin
          clk_lvl = 1'b0;
          phase = PH_DATA;
        end
        PH_DATA: begin
          dio_lvl = shifter[0];
          phase = PH_CLK_HIGH;
        end
        PH_CLK_HIGH: begin
          clk_lvl = 1'b1;
          shifter = shifter >> 1;
          if (bit_idx == 3'd7) begin
            bit_idx = '0;
            phase = PH_BYTE_END;
          end else begin
            bit_idx = bit_idx + 3'd1;
            phase = PH_CLK_LOW;
          end
        end
        PH_BYTE_END: begin
          clk_lvl = 1'b0;
          if (frame == 2'd1 && byte_idx < send_count && byte_idx < BUFFER_DEPTH) begin
            shifter = segs[byte_idx];
            byte_idx = byte_idx + 5'd1;
            phase = PH_CLK_LOW;
          end else begin
            phase = PH_STOP_DIO;
          end
        end
        PH_STOP_DIO: begin
          dio_lvl = 1'b0;
          phase = PH_STOP_CLK;
        end
        PH_STOP_CLK: begin
          clk_lvl = 1'b1;
          phase = PH_STOP_REL;
        end
        PH_STOP_REL: begin
          dio_lvl = 1'b1;
          if (frame >= 2'd2) begin
            frame = '0;
            byte_idx = '0;
            phase = PH_IDLE;
          end else begin
            frame = frame + 2'd1;
            open_frame();
          end
        end
        default: phase = PH_IDLE;
      endcase
    endfunction

    function void note_request(in_item_t it);
      out_item_t pins;
      bit idle;
      idle = (phase == PH_IDLE);
      case (it.func)
        FUNC_LOAD: begin
          if (idle && it.slot < BUFFER_DEPTH) begin
            segs[it.slot] = it.seg_byte;
            loaded[it.slot] = 1'b1;
          end
        end
        FUNC_START: begin
          if (idle) begin
            send_count = (it.byte_count > BUFFER_DEPTH) ? 5'(BUFFER_DEPTH) : it.byte_count;
            digit = it.first_digit;
            frame = '0;
            open_frame();
          end
        end
        FUNC_TICK: begin
          step_pins();
          pins.clk_line = clk_lvl;
          pins.dio_line = dio_lvl;
          pins.busy_res = (phase != PH_IDLE);
          expected_pins.push_back(pins);
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (expected_pins.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %b", $time, got);
        return;
      end
      want = expected_pins.pop_front();
      if (got.clk_line !== want.clk_line) begin
        errors++;
        $display("%0t: clk_line expected %b actual %b", $time, want.clk_line, got.clk_line);
      end
      if (got.dio_line !== want.dio_line) begin
        errors++;
        $display("%0t: dio_line expected %b actual %b", $time, want.dio_line, got.dio_line);
      end
      if (got.busy_res !== want.busy_res) begin
        errors++;
        $display("%0t: busy_res expected %b actual %b", $time, want.busy_res, got.busy_res);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  in_item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  out_item_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pin_scoreboard sb;
  bit calm = 1'b0;
  int useful = 0;
  int cycles = 0;

  led_driver_two_wire_writer dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [7:0] pick_seg();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic in_item_t make_request();
    in_item_t it;
    int r;
    int r2;
    int lim;
    it.slot = 4'($urandom_range(0, 15));
    it.seg_byte = pick_seg();
    it.byte_count = 5'($urandom_range(0, 31));
    it.first_digit = 2'($urandom_range(0, 3));
    r = $urandom_range(0, 99);
    if (sb.busy()) begin
      if (r < 90) it.func = FUNC_TICK;
      else if (r < 94) it.func = FUNC_LOAD;
      else if (r < 97) it.func = FUNC_START;
      else it.func = FUNC_NONE;
    end else begin
      lim = sb.loaded_prefix();
      r2 = $urandom_range(0, 99);
      if (r < 45) begin
        it.func = FUNC_LOAD;
        if (lim < BUFFER_DEPTH && r < 25) it.slot = 4'(lim);
      end else if (r < 80) begin
        it.func = FUNC_START;
        if (lim == BUFFER_DEPTH) begin
          if (r2 < 65) it.byte_count = 5'($urandom_range(0, 3));
          else if (r2 < 90) it.byte_count = 5'($urandom_range(4, 16));
          else it.byte_count = 5'($urandom_range(16, 31));
        end else if (lim > 3 && r2 < 65) begin
          it.byte_count = 5'($urandom_range(0, 3));
        end else begin
          it.byte_count = 5'($urandom_range(0, lim));
        end
      end else if (r < 95) begin
        it.func = FUNC_TICK;
      end else begin
        it.func = FUNC_NONE;
      end
    end
    return it;
  endfunction

  task automatic push_request(in_item_t it);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    if (it.func == FUNC_TICK || (!sb.busy() && it.func != FUNC_NONE)) useful++;
    sb.note_request(it);
  endtask

  task automatic push_fields(logic [1:0] func, logic [3:0] slot, logic [7:0] seg,
                             logic [4:0] count, logic [1:0] first);
    in_item_t it;
    it.func = func;
    it.slot = slot;
    it.seg_byte = seg;
    it.byte_count = count;
    it.first_digit = first;
    push_request(it);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (sb.expected_pins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(logic [2:0] bri, logic [CFG_DATA_W-1:0] on_data);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_BRIGHTNESS;
    cfg_data <= bri;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_config(CFG_BRIGHTNESS, bri);
    cfg_index <= CFG_DISPLAY_ON;
    cfg_data <= on_data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_config(CFG_DISPLAY_ON, on_data);
    cfg_valid <= 1'b0;
  endtask

  initial begin : result_side
    int hold;
    bit long_done;
    hold = 0;
    long_done = 1'b0;
    forever begin
      @(posedge clk);
      if (result_valid && result_ready) sb.check_result(result);
      if (!long_done && sb.results_seen >= 50) begin
        hold = 400;
        long_done = 1'b1;
      end else if (hold == 0 && !calm && $urandom_range(0, 3) == 0) begin
        hold = pick_gap();
      end
      result_ready <= (hold == 0);
      if (hold > 0) hold--;
    end
  end

  initial begin : stimulus
    int p;
    logic [2:0] bri;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    push_fields(FUNC_TICK, 4'd0, 8'h00, 5'd0, 2'd0);
    push_fields(FUNC_NONE, 4'd15, 8'hFF, 5'd31, 2'd3);
    push_fields(FUNC_LOAD, 4'd0, 8'hFF, 5'd0, 2'd0);
    push_fields(FUNC_LOAD, 4'd1, 8'h00, 5'd0, 2'd0);
    push_fields(FUNC_LOAD, 4'd2, 8'h01, 5'd0, 2'd0);
    push_fields(FUNC_LOAD, 4'd3, 8'h80, 5'd0, 2'd0);
    push_fields(FUNC_LOAD, 4'd15, 8'hA5, 5'd0, 2'd0);
    push_fields(FUNC_START, 4'd0, 8'h00, 5'd0, 2'd3);
    push_fields(FUNC_LOAD, 4'd4, 8'h3C, 5'd0, 2'd0);
    push_fields(FUNC_START, 4'd0, 8'h00, 5'd16, 2'd1);
    repeat (12) push_fields(FUNC_TICK, 4'd0, 8'h00, 5'd0, 2'd0);

    for (p = 0; p < PHASES; p++) begin
      calm = (p % 3 == 2);
      while (useful < ITEM_TARGET * (p + 1) / PHASES || sb.busy())
        push_request(make_request());
      drain();
      if (p < PHASES - 1) begin
        bri = (p == 0) ? 3'd0 : (p == 1) ? 3'd7 : 3'($urandom_range(0, 7));
        write_settings(bri, {2'($urandom_range(0, 3)), 1'(p % 2)});
      end
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_pins.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
design/lddw_pkg.sv
design/lddw_core.sv
design/led_driver_two_wire_writer.sv
design/lddw_checker.sv
tb/sv/tb_led_driver_two_wire_writer.sv
